// File: hw/rtl/rbfw_pkg.sv
// rbfw_pkg: shared types, constants and helper functions for the RBF warp unit.
// Used by rbfw_sqdiv and rbf_image_warp_eval_unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package rbfw_pkg;

    // default sizing
    localparam int RBFW_MAX_POINTS = 64;
    localparam int RBFW_COORD_BITS = 12;

    // accumulator holds affine part plus up to 1024 clamped terms
    localparam int ACC_W = 52;

    // iteration counts of the root / divide unit
    localparam int ROOT_STEPS = 32;
    localparam int DIV_STEPS  = 49;
    localparam int STEP_W     = 6;

    // item modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_WARP = 1'b1;

    // register indexes
    localparam logic [2:0] REG_MAT_XX      = 3'd0;
    localparam logic [2:0] REG_MAT_XY      = 3'd1;
    localparam logic [2:0] REG_MAT_YX      = 3'd2;
    localparam logic [2:0] REG_MAT_YY      = 3'd3;
    localparam logic [2:0] REG_SHIFT_X     = 3'd4;
    localparam logic [2:0] REG_SHIFT_Y     = 3'd5;
    localparam logic [2:0] REG_EXPONENT    = 3'd6;
    localparam logic [2:0] REG_POINT_COUNT = 3'd7;

    // exponent codes after clamping
    localparam logic signed [2:0] EXP_NEG_TWO = -3'sd2;
    localparam logic signed [2:0] EXP_NEG_ONE = -3'sd1;
    localparam logic signed [2:0] EXP_ZERO    = 3'sd0;
    localparam logic signed [2:0] EXP_ONE     = 3'sd1;
    localparam logic signed [2:0] EXP_TWO     = 3'sd2;

    localparam logic [31:0] BASIS_MAX = 32'hFFFF_FFFF;
    localparam logic [31:0] BASIS_ONE = 32'h0001_0000;

    // root / divide unit request
    typedef enum logic {SQ_ROOT, SQ_DIV} sq_op_t;

    typedef struct packed {
        logic   start;
        sq_op_t op;
    } sq_req_t;

    // fold out-of-range exponent codes onto the end values
    function automatic logic signed [2:0] exp_clamp(input logic signed [2:0] u);
        logic signed [2:0] r;
        r = u;
        if (u == 3'sd3)
            r = EXP_TWO;
        else if (u == -3'sd4 || u == -3'sd3)
            r = EXP_NEG_TWO;
        return r;
    endfunction

    // saturate to signed 32 bits, flag in the top bit of the result
    function automatic logic [32:0] clamp32(input logic signed [ACC_W-1:0] v);
        logic [32:0] r;
        if (v > ACC_W'(64'sh7FFF_FFFF))
            r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -ACC_W'(64'sh8000_0000))
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rbfw_ram.sv
// rbfw_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rbfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: hw/rtl/rbfw_sqdiv.sv
// rbfw_sqdiv: iterative integer square root (one result bit per cycle) and
// restoring divider (one quotient bit per cycle). Depends on rbfw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rbfw_sqdiv
    import rbfw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire sq_req_t     req,
    input  wire logic [63:0] arg,     // radicand, or divisor
    input  wire logic [48:0] num,     // dividend
    output logic             done,
    output logic [63:0]      result
);

    logic              run_reg;
    sq_op_t            op_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [63:0]       a_reg;      // remaining radicand or partial remainder
    logic [63:0]       r_reg;      // root or quotient
    logic [63:0]       b_reg;      // root bit, or dividend bits left
    logic [63:0]       d_reg;      // divisor

    logic [63:0] trial;
    logic [64:0] rem_sh;
    assign trial  = r_reg + b_reg;
    assign rem_sh = {a_reg, b_reg[DIV_STEPS-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done    <= 1'b0;
            cnt_reg <= '0;
            op_reg  <= SQ_ROOT;
        end
        else
        begin
            done <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                op_reg  <= req.op;
                r_reg   <= '0;
                d_reg   <= arg;
                if (req.op == SQ_ROOT)
                begin
                    a_reg   <= arg;
                    b_reg   <= 64'h4000_0000_0000_0000;
                    cnt_reg <= STEP_W'(ROOT_STEPS);
                end
                else
                begin
                    a_reg   <= '0;
                    b_reg   <= 64'(num);
                    cnt_reg <= STEP_W'(DIV_STEPS);
                end
            end
            else if (run_reg)
            begin
                // one root or quotient bit
                if (op_reg == SQ_ROOT)
                begin
                    if (a_reg >= trial)
                    begin
                        a_reg <= a_reg - trial;
                        r_reg <= (r_reg >> 1) + b_reg;
                    end
                    else
                        r_reg <= r_reg >> 1;
                    b_reg <= b_reg >> 2;
                end
                else
                begin
                    if (rem_sh >= {1'b0, d_reg})
                    begin
                        a_reg <= 64'(rem_sh - {1'b0, d_reg});
                        r_reg <= {r_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        a_reg <= rem_sh[63:0];
                        r_reg <= {r_reg[62:0], 1'b0};
                    end
                    b_reg <= b_reg << 1;
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
            end
        end
    end

    assign result = r_reg;

endmodule
`default_nettype wire

// File: hw/rtl/rbf_image_warp_eval_unit.sv
// rbf_image_warp_eval_unit: top level of the RBF warp evaluator.
// Depends on rbfw_pkg, rbfw_ram and rbfw_sqdiv.
//
// A load beat (mode 0) writes one control point into the table. A warp beat
// (mode 1) computes the affine part and then, per summed point, the squared
// distance plus squared radius and a basis: set directly for exponent 0 or 2,
// a root for exponent 1, a divide for -2 and a root then a divide for -1. The
// 33x33 multiplier and the one-bit-per-cycle root/divide unit are shared. busy
// stays high for the whole warp. The result appears on out_x, out_y and
// saturated with done high for one cycle; the receiver must take it then.
`timescale 1ns / 1ps
`default_nettype none
module rbf_image_warp_eval_unit
    import rbfw_pkg::*;
#(
    parameter int MAX_POINTS = RBFW_MAX_POINTS,
    parameter int COORD_BITS = RBFW_COORD_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        mode,
    input  wire logic [5:0]  slot,
    input  wire logic [11:0] pos_x,
    input  wire logic [11:0] pos_y,
    input  wire logic signed [31:0] weight_x,
    input  wire logic signed [31:0] weight_y,
    input  wire logic [27:0] radius,
    output logic             done,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic             saturated
);

    localparam int ADDR_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int ENTRY_W = 2 * COORD_BITS + 92;
    localparam int D2_W    = 2 * COORD_BITS + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_AXX, S_AXY, S_AYX, S_AYY, S_AEND,
        S_FETCH, S_DX, S_DY, S_RR, S_SUM, S_BAS,
        S_ROOT, S_DIVW, S_TX, S_TY, S_TEND, S_DONE
    } state_t;

    // configuration registers
    logic signed [20:0] mat_xx_reg, mat_xy_reg, mat_yx_reg, mat_yy_reg;
    logic signed [31:0] shift_x_reg, shift_y_reg;
    logic signed [2:0]  exponent_reg;
    logic [6:0]         point_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_xx_reg      <= 21'sd65536;
            mat_xy_reg      <= '0;
            mat_yx_reg      <= '0;
            mat_yy_reg      <= 21'sd65536;
            shift_x_reg     <= '0;
            shift_y_reg     <= '0;
            exponent_reg    <= 3'sd1;
            point_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAT_XX:      mat_xx_reg      <= cfg_data[20:0];
                REG_MAT_XY:      mat_xy_reg      <= cfg_data[20:0];
                REG_MAT_YX:      mat_yx_reg      <= cfg_data[20:0];
                REG_MAT_YY:      mat_yy_reg      <= cfg_data[20:0];
                REG_SHIFT_X:     shift_x_reg     <= cfg_data;
                REG_SHIFT_Y:     shift_y_reg     <= cfg_data;
                REG_EXPONENT:    exponent_reg    <= cfg_data[2:0];
                REG_POINT_COUNT: point_count_reg <= cfg_data[6:0];
                default:         ;
            endcase
        end
    end

    state_t state_reg;

    logic [COORD_BITS-1:0] px_reg, py_reg;
    logic [CNT_W-1:0]      k_reg, n_reg;
    logic signed [ACC_W-1:0] acc_x_reg, acc_y_reg;
    logic                  sat_reg;
    logic signed [31:0]    wx_reg, wy_reg;
    logic [COORD_BITS-1:0] dy_reg;
    logic [27:0]           r_reg;
    logic [D2_W-1:0]       d2_reg;
    logic [63:0]           s_reg;
    logic [31:0]           b_reg;
    logic signed [65:0]    prod_reg;

    // control point table
    logic [31:0]         slot_wide;
    logic                load_we;
    logic [ENTRY_W-1:0]  wr_entry, rd_entry;
    logic [COORD_BITS-1:0] in_px, in_py;

    assign slot_wide = 32'(slot);
    assign in_px     = COORD_BITS'(pos_x);
    assign in_py     = COORD_BITS'(pos_y);
    assign load_we   = start && !busy && (mode == MODE_LOAD)
                       && (slot_wide < 32'(MAX_POINTS));
    assign wr_entry  = {radius, weight_y, weight_x, in_py, in_px};

    rbfw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (slot_wide[ADDR_W-1:0]),
        .wdata (wr_entry),
        .raddr (k_reg[ADDR_W-1:0]),
        .rdata (rd_entry)
    );

    // fields of the entry just read
    logic [COORD_BITS-1:0] qx, qy, dx, dy;
    assign qx = rd_entry[COORD_BITS-1:0];
    assign qy = rd_entry[2*COORD_BITS-1:COORD_BITS];
    assign dx = (px_reg > qx) ? px_reg - qx : qx - px_reg;
    assign dy = (py_reg > qy) ? py_reg - qy : qy - py_reg;

    // shared multiplier operand select
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_next;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_AXX:   begin mul_a = 33'(mat_xx_reg); mul_b = 33'(px_reg); end
            S_AXY:   begin mul_a = 33'(mat_xy_reg); mul_b = 33'(py_reg); end
            S_AYX:   begin mul_a = 33'(mat_yx_reg); mul_b = 33'(px_reg); end
            S_AYY:   begin mul_a = 33'(mat_yy_reg); mul_b = 33'(py_reg); end
            S_DX:    begin mul_a = 33'(dx);          mul_b = 33'(dx);     end
            S_DY:    begin mul_a = 33'(dy_reg);      mul_b = 33'(dy_reg); end
            S_RR:    begin mul_a = 33'(r_reg);       mul_b = 33'(r_reg);  end
            S_TX:    begin mul_a = 33'(wx_reg);      mul_b = 33'(b_reg);  end
            S_TY:    begin mul_a = 33'(wy_reg);      mul_b = 33'(b_reg);  end
            default: ;
        endcase
        prod_next = mul_a * mul_b;
    end

    // term = floor(w * b / 2^16), saturated
    logic signed [65:0] term_wide;
    logic [32:0]        term_c;
    logic [32:0]        fin_x, fin_y;
    logic [63:0]        s_next;
    logic signed [2:0]  u_eff;

    assign term_wide = prod_reg >>> 16;
    assign term_c    = clamp32(ACC_W'(term_wide));
    assign fin_x     = clamp32(acc_x_reg);
    assign fin_y     = clamp32(acc_y_reg);
    assign s_next    = {32'(d2_reg), 32'b0} + prod_reg[63:0];
    assign u_eff     = exp_clamp(exponent_reg);

    // root / divide unit
    sq_req_t     sq_req;
    logic [63:0] sq_arg;
    logic [48:0] sq_num;
    logic        sq_done;
    logic [63:0] sq_res;

    always_comb
    begin
        sq_req.start = 1'b0;
        sq_req.op    = SQ_ROOT;
        sq_arg       = s_reg;
        sq_num       = 49'h1_0000_0000_0000;
        if (state_reg == S_BAS)
        begin
            if (u_eff == EXP_ONE || u_eff == EXP_NEG_ONE)
                sq_req.start = 1'b1;
            else if (u_eff == EXP_NEG_TWO && s_reg != '0)
            begin
                sq_req.start = 1'b1;
                sq_req.op    = SQ_DIV;
            end
        end
        else if (state_reg == S_ROOT && sq_done && u_eff == EXP_NEG_ONE
                 && sq_res != '0)
        begin
            sq_req.start = 1'b1;
            sq_req.op    = SQ_DIV;
            sq_arg       = sq_res;
            sq_num       = 49'h0_0001_0000_0000;
        end
    end

    rbfw_sqdiv u_sqdiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (sq_req),
        .arg    (sq_arg),
        .num    (sq_num),
        .done   (sq_done),
        .result (sq_res)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
            k_reg     <= '0;
            n_reg     <= '0;
        end
        else
        begin
            done     <= 1'b0;
            prod_reg <= prod_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (start && mode == MODE_WARP)
                    begin
                        px_reg    <= in_px;
                        py_reg    <= in_py;
                        k_reg     <= '0;
                        n_reg     <= (32'(point_count_reg) > 32'(MAX_POINTS))
                                     ? CNT_W'(MAX_POINTS) : CNT_W'(point_count_reg);
                        sat_reg   <= 1'b0;
                        state_reg <= S_AXX;
                    end
                end
                S_AXX:
                begin
                    acc_x_reg <= ACC_W'(shift_x_reg);
                    acc_y_reg <= ACC_W'(shift_y_reg);
                    state_reg <= S_AXY;
                end
                S_AXY:
                begin
                    acc_x_reg <= acc_x_reg + ACC_W'(prod_reg);
                    state_reg <= S_AYX;
                end
                S_AYX:
                begin
                    acc_x_reg <= acc_x_reg + ACC_W'(prod_reg);
                    state_reg <= S_AYY;
                end
                S_AYY:
                begin
                    acc_y_reg <= acc_y_reg + ACC_W'(prod_reg);
                    state_reg <= S_AEND;
                end
                S_AEND:
                begin
                    acc_y_reg <= acc_y_reg + ACC_W'(prod_reg);
                    state_reg <= (n_reg == '0) ? S_DONE : S_FETCH;
                end
                S_FETCH:
                    state_reg <= S_DX;
                S_DX:
                begin
                    wx_reg    <= rd_entry[2*COORD_BITS +: 32];
                    wy_reg    <= rd_entry[2*COORD_BITS+32 +: 32];
                    r_reg     <= rd_entry[2*COORD_BITS+64 +: 28];
                    dy_reg    <= dy;
                    state_reg <= S_DY;
                end
                S_DY:
                begin
                    d2_reg    <= D2_W'(prod_reg);
                    state_reg <= S_RR;
                end
                S_RR:
                begin
                    d2_reg    <= d2_reg + D2_W'(prod_reg);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    s_reg     <= s_next;
                    state_reg <= S_BAS;
                end
                S_BAS:
                begin
                    // pick the basis path by exponent
                    if (u_eff == EXP_ZERO)
                    begin
                        b_reg     <= BASIS_ONE;
                        state_reg <= S_TX;
                    end
                    else if (u_eff == EXP_TWO)
                    begin
                        if (s_reg[63:48] != '0)
                        begin
                            b_reg   <= BASIS_MAX;
                            sat_reg <= 1'b1;
                        end
                        else
                            b_reg <= s_reg[47:16];
                        state_reg <= S_TX;
                    end
                    else if (u_eff == EXP_NEG_TWO)
                    begin
                        if (s_reg == '0)
                        begin
                            b_reg     <= BASIS_MAX;
                            sat_reg   <= 1'b1;
                            state_reg <= S_TX;
                        end
                        else
                            state_reg <= S_DIVW;
                    end
                    else
                        state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    if (sq_done)
                    begin
                        if (u_eff == EXP_ONE)
                        begin
                            b_reg     <= sq_res[31:0];
                            state_reg <= S_TX;
                        end
                        else if (sq_res == '0)
                        begin
                            // zero base under a negative exponent
                            b_reg     <= BASIS_MAX;
                            sat_reg   <= 1'b1;
                            state_reg <= S_TX;
                        end
                        else
                            state_reg <= S_DIVW;
                    end
                end
                S_DIVW:
                begin
                    if (sq_done)
                    begin
                        if (sq_res[63:32] != '0)
                        begin
                            b_reg   <= BASIS_MAX;
                            sat_reg <= 1'b1;
                        end
                        else
                            b_reg <= sq_res[31:0];
                        state_reg <= S_TX;
                    end
                end
                S_TX:
                    state_reg <= S_TY;
                S_TY:
                begin
                    acc_x_reg <= acc_x_reg + ACC_W'($signed(term_c[31:0]));
                    if (term_c[32])
                        sat_reg <= 1'b1;
                    state_reg <= S_TEND;
                end
                S_TEND:
                begin
                    acc_y_reg <= acc_y_reg + ACC_W'($signed(term_c[31:0]));
                    if (term_c[32])
                        sat_reg <= 1'b1;
                    k_reg <= k_reg + 1'b1;
                    state_reg <= (k_reg + 1'b1 == n_reg) ? S_DONE : S_FETCH;
                end
                S_DONE:
                begin
                    out_x     <= fin_x[31:0];
                    out_y     <= fin_y[31:0];
                    saturated <= sat_reg | fin_x[32] | fin_y[32];
                    done      <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);

    // checks
    a_warp_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && mode == MODE_WARP |=> busy)
        else $error("warp beat did not start the sequencer");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_unit_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (state_reg == S_ROOT || state_reg == S_DIVW))
        else $error("root/divide finished outside a wait state");

endmodule
`default_nettype wire
